// ===== rtl/fsd_pkg.sv =====
// Shared types, constants and functions of the framed stream deframer.
// Holds the item and result structs, status codes and the CRC-32C byte step.
// Depends on nothing.
package fsd_pkg;

   localparam int DataWidth     = 8;
   localparam int SizeWidth     = 24;
   localparam int CrcWidth      = 32;
   localparam int StatusWidth   = 4;
   localparam int RspDataWidth  = 48;

   localparam logic [CrcWidth-1:0]  CrcPolyRefl = 32'h82F6_3B78;
   localparam logic [CrcWidth-1:0]  CrcAllOnes  = 32'hFFFF_FFFF;
   localparam logic [CrcWidth-1:0]  CrcMaskAdd  = 32'hA282_EAD8;
   localparam logic [SizeWidth-1:0] MaxBlockSizeReset = 24'd65536;
   localparam logic [SizeWidth-1:0] IdentSize   = 24'd6;
   localparam logic [SizeWidth-1:0] CheckSize   = 24'd4;

   localparam logic [7:0] KindCompressed   = 8'h00;
   localparam logic [7:0] KindUncompressed = 8'h01;
   localparam logic [7:0] LastUnskippable  = 8'h7F;
   localparam logic [7:0] KindIdent        = 8'hFF;

   localparam logic [StatusWidth-1:0] StOk        = 4'd0;
   localparam logic [StatusWidth-1:0] StBadIdent  = 4'd1;
   localparam logic [StatusWidth-1:0] StIdentLen  = 4'd2;
   localparam logic [StatusWidth-1:0] StMagic     = 4'd3;
   localparam logic [StatusWidth-1:0] StShort     = 4'd4;
   localparam logic [StatusWidth-1:0] StLarge     = 4'd5;
   localparam logic [StatusWidth-1:0] StChecksum  = 4'd6;
   localparam logic [StatusWidth-1:0] StReserved  = 4'd7;
   localparam logic [StatusWidth-1:0] StEarlyEnd  = 4'd8;
   localparam logic [StatusWidth-1:0] StCleanEnd  = 4'd9;

   typedef struct packed {
      logic                 op;
      logic [DataWidth-1:0] data_byte;
   } item_type;

   typedef struct packed {
      logic                   has_byte;
      logic [DataWidth-1:0]   out_byte;
      logic                   compressed_payload;
      logic                   chunk_end;
      logic [StatusWidth-1:0] status;
      logic [CrcWidth-1:0]    expected_checksum;
   } result_type;

   function automatic logic [CrcWidth-1:0] crc_byte(input logic [CrcWidth-1:0] crc,
                                                    input logic [DataWidth-1:0] b);
      logic [CrcWidth-1:0] c;
      c = crc ^ {24'd0, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CrcPolyRefl) : (c >> 1);
      end
      return c;
   endfunction

   function automatic logic [CrcWidth-1:0] masked_final(input logic [CrcWidth-1:0] crc);
      logic [CrcWidth-1:0] c;
      c = crc ^ CrcAllOnes;
      return {c[14:0], c[31:15]} + CrcMaskAdd;
   endfunction

   function automatic logic [DataWidth-1:0] magic_char(input logic [2:0] pos);
      logic [DataWidth-1:0] ch;
      unique case (pos)
         3'd0: ch = 8'h73;
         3'd1: ch = 8'h4E;
         3'd2: ch = 8'h61;
         3'd3: ch = 8'h50;
         3'd4: ch = 8'h70;
         3'd5: ch = 8'h59;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

// ===== rtl/fsd_in_stage.sv =====
// Input register of the deframer: holds one accepted stream transfer.
// Uses the item type from fsd_pkg.
module fsd_in_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic              req_tuser,   // op
   input  logic [7:0]        req_tdata,   // data_byte
   input  logic              take,
   output logic              item_valid,
   output fsd_pkg::item_type item
);
   import fsd_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   logic     accept;

   assign req_tready = !valid_ff || take;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (accept) begin
         valid_in = 1'b1;
         item_in  = '{op: req_tuser, data_byte: req_tdata};
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ===== rtl/fsd_parser.sv =====
// Chunk parser of the deframer: header assembly, length checks, payload
// forwarding and CRC-32C checking for one byte per step. Uses fsd_pkg.
module fsd_parser (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [23:0]         csr_wr_data,
   input  logic                step_en,
   input  fsd_pkg::item_type   item,
   output logic                res_valid,
   output fsd_pkg::result_type res
);
   import fsd_pkg::*;

   localparam logic [1:0] PhStreamHdr = 2'd0;
   localparam logic [1:0] PhChunkHdr  = 2'd1;
   localparam logic [1:0] PhChunkBody = 2'd2;
   localparam logic [1:0] PhError     = 2'd3;

   logic [1:0]           phase_ff, phase_in;
   logic [1:0]           hdr_idx_ff, hdr_idx_in;
   logic [7:0]           kind_ff, kind_in;
   logic [SizeWidth-1:0] size_ff, size_in;
   logic [SizeWidth-1:0] count_ff, count_in;
   logic [CrcWidth-1:0]  stored_ff, stored_in;
   logic [CrcWidth-1:0]  crc_ff, crc_in;
   logic                 magic_ff, magic_in;
   logic [SizeWidth-1:0] max_size_ff;

   logic [DataWidth-1:0] b;
   logic [SizeWidth-1:0] hdr_size;
   logic                 hdr_done;
   logic [SizeWidth-1:0] count_next;
   logic                 last;
   logic                 is_data;
   logic                 comp;
   logic                 body_has;
   logic [CrcWidth-1:0]  stored_new;
   logic [CrcWidth-1:0]  crc_new;
   logic                 sum_bad;

   assign b = item.data_byte;

   always_comb begin
      hdr_size = size_ff;
      unique case (hdr_idx_ff)
         2'd0: hdr_size = '0;
         2'd1: hdr_size = {size_ff[23:8], b};
         2'd2: hdr_size = {size_ff[23:16], b, size_ff[7:0]};
         2'd3: hdr_size = {b, size_ff[15:0]};
      endcase
   end
   assign hdr_done = (hdr_idx_ff == 2'd3);

   assign count_next = count_ff + 24'd1;
   assign last       = (count_next == size_ff);
   assign is_data    = (kind_ff == KindCompressed) || (kind_ff == KindUncompressed);
   assign comp       = (kind_ff == KindCompressed);
   assign body_has   = (count_ff >= CheckSize);

   always_comb begin
      stored_new = stored_ff;
      if (!body_has) begin
         unique case (count_ff[1:0])
            2'd0: stored_new[7:0]   = b;
            2'd1: stored_new[15:8]  = b;
            2'd2: stored_new[23:16] = b;
            2'd3: stored_new[31:24] = b;
         endcase
      end
   end
   assign crc_new = (body_has && !comp) ? crc_byte(crc_ff, b) : crc_ff;
   assign sum_bad = !comp && (masked_final(crc_new) != stored_new);

   always_comb begin
      phase_in   = phase_ff;
      hdr_idx_in = hdr_idx_ff;
      kind_in    = kind_ff;
      size_in    = size_ff;
      count_in   = count_ff;
      stored_in  = stored_ff;
      crc_in     = crc_ff;
      magic_in   = magic_ff;
      res_valid  = 1'b0;
      res        = '0;
      if (item.op) begin
         if (phase_ff != PhError) begin
            res_valid     = 1'b1;
            res.chunk_end = 1'b1;
            res.status    = (phase_ff == PhChunkHdr && hdr_idx_ff == 2'd0) ? StCleanEnd
                                                                           : StEarlyEnd;
         end
         phase_in   = PhStreamHdr;
         hdr_idx_in = '0;
         kind_in    = '0;
         size_in    = '0;
         count_in   = '0;
         stored_in  = '0;
         crc_in     = CrcAllOnes;
         magic_in   = 1'b1;
      end else begin
         unique case (phase_ff)
            PhStreamHdr, PhChunkHdr: begin
               size_in = hdr_size;
               if (hdr_idx_ff == 2'd0) begin
                  kind_in    = b;
                  hdr_idx_in = 2'd1;
               end else if (!hdr_done) begin
                  hdr_idx_in = hdr_idx_ff + 2'd1;
               end else begin
                  hdr_idx_in = 2'd0;
                  count_in   = '0;
                  stored_in  = '0;
                  crc_in     = CrcAllOnes;
                  magic_in   = 1'b1;
                  phase_in   = PhChunkBody;
                  res.chunk_end = 1'b1;
                  priority if (phase_ff == PhStreamHdr && kind_ff != KindIdent) begin
                     res_valid = 1'b1;
                     res.status = StBadIdent;
                  end else if (kind_ff == KindIdent) begin
                     if (hdr_size != IdentSize) begin
                        res_valid = 1'b1;
                        res.status = StIdentLen;
                     end
                  end else if (kind_ff == KindCompressed || kind_ff == KindUncompressed) begin
                     if (hdr_size < CheckSize) begin
                        res_valid = 1'b1;
                        res.status = StShort;
                     end else if (kind_ff == KindUncompressed &&
                                  (hdr_size - CheckSize) > max_size_ff) begin
                        res_valid = 1'b1;
                        res.status = StLarge;
                     end
                  end else if (kind_ff <= LastUnskippable) begin
                     res_valid = 1'b1;
                     res.status = StReserved;
                  end else if (hdr_size == '0) begin
                     phase_in = PhChunkHdr;
                  end else begin
                     phase_in = PhChunkBody;
                  end
                  if (res_valid) begin
                     phase_in  = PhError;
                     count_in  = count_ff;
                     stored_in = stored_ff;
                     crc_in    = crc_ff;
                     magic_in  = magic_ff;
                  end else begin
                     res.chunk_end = 1'b0;
                  end
               end
            end
            PhChunkBody: begin
               count_in = count_next;
               if (kind_ff == KindIdent) begin
                  if (count_ff >= IdentSize || magic_char(count_ff[2:0]) != b) begin
                     magic_in = 1'b0;
                  end
                  if (last) begin
                     if (!magic_in) begin
                        res_valid     = 1'b1;
                        res.chunk_end = 1'b1;
                        res.status    = StMagic;
                        phase_in      = PhError;
                     end else begin
                        phase_in = PhChunkHdr;
                     end
                  end
               end else if (is_data) begin
                  stored_in = stored_new;
                  crc_in    = crc_new;
                  res.compressed_payload = comp;
                  if (body_has) begin
                     res_valid    = 1'b1;
                     res.has_byte = 1'b1;
                     res.out_byte = b;
                  end
                  if (last) begin
                     res_valid             = 1'b1;
                     res.chunk_end         = 1'b1;
                     res.expected_checksum = stored_new;
                     res.status            = sum_bad ? StChecksum : StOk;
                     phase_in              = sum_bad ? PhError : PhChunkHdr;
                  end
               end else if (last) begin
                  phase_in = PhChunkHdr;
               end
            end
            PhError: begin
               phase_in = PhError;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PhStreamHdr;
         hdr_idx_ff  <= '0;
         kind_ff     <= '0;
         size_ff     <= '0;
         count_ff    <= '0;
         stored_ff   <= '0;
         crc_ff      <= CrcAllOnes;
         magic_ff    <= 1'b1;
         max_size_ff <= MaxBlockSizeReset;
      end else begin
         if (step_en) begin
            phase_ff   <= phase_in;
            hdr_idx_ff <= hdr_idx_in;
            kind_ff    <= kind_in;
            size_ff    <= size_in;
            count_ff   <= count_in;
            stored_ff  <= stored_in;
            crc_ff     <= crc_in;
            magic_ff   <= magic_in;
         end
         if (csr_wr_en) begin
            max_size_ff <= csr_wr_data;
         end
      end
   end

   a_error_sticks: assert property (@(posedge clock) disable iff (reset)
      step_en && !item.op && res_valid && res.chunk_end && res.status != StOk
      |=> phase_ff == PhError)
      else $error("error transfer did not enter the error phase");

   a_eos_clears: assert property (@(posedge clock) disable iff (reset)
      step_en && item.op
      |=> phase_ff == PhStreamHdr && hdr_idx_ff == 2'd0 && crc_ff == CrcAllOnes)
      else $error("end of stream did not restore the parser");

   a_byte_in_body: assert property (@(posedge clock) disable iff (reset)
      step_en && res_valid && res.has_byte |-> phase_ff == PhChunkBody && is_data)
      else $error("payload byte forwarded outside a data chunk body");

   a_error_silent: assert property (@(posedge clock) disable iff (reset)
      step_en && !item.op && phase_ff == PhError |-> !res_valid)
      else $error("result produced in the error phase");

endmodule

// ===== rtl/fsd_out_stage.sv =====
// Result register of the deframer: holds one result until the sink takes it.
// Uses the result type from fsd_pkg.
module fsd_out_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  fsd_pkg::result_type res,
   output logic                out_ready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [1:0]          rsp_tuser,  // has_byte, compressed_payload
   output logic [47:0]         rsp_tdata,  // out_byte, status, expected_checksum, zero fill
   output logic                rsp_tlast   // chunk_end
);
   import fsd_pkg::*;

   logic       valid_ff, valid_in;
   result_type res_ff, res_in;

   assign out_ready = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      res_in   = res_ff;
      if (load) begin
         valid_in = 1'b1;
         res_in   = res;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      res_ff <= res_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = {res_ff.compressed_payload, res_ff.has_byte};
   assign rsp_tdata  = {4'd0, res_ff.expected_checksum, res_ff.status, res_ff.out_byte};
   assign rsp_tlast  = res_ff.chunk_end;

endmodule

// ===== rtl/framed_stream_deframer_core.sv =====
// Framed stream deframer: input register, chunk parser and result register.
// Depends on fsd_pkg, fsd_in_stage, fsd_parser and fsd_out_stage.
// Items pass the input register, then the parser; results go to the result register.
// Throughput is one item per cycle unless the result register is full and rsp is stalled.
// Synchronous reset clears both stages and the parser and sets max_block_size to 65536.
module framed_stream_deframer_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [23:0] csr_wr_data,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic        req_tuser,   // op
   input  logic [7:0]  req_tdata,   // data_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [1:0]  rsp_tuser,   // has_byte, compressed_payload
   output logic [47:0] rsp_tdata,   // out_byte, status, expected_checksum, zero fill
   output logic        rsp_tlast    // chunk_end
);
   import fsd_pkg::*;

   item_type   item;
   result_type res;
   logic       item_valid;
   logic       out_ready;
   logic       step_en;
   logic       res_valid;

   assign step_en = item_valid && out_ready;

   fsd_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .take       (out_ready),
      .item_valid (item_valid),
      .item       (item)
   );

   fsd_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .step_en     (step_en),
      .item        (item),
      .res_valid   (res_valid),
      .res         (res)
   );

   fsd_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .load       (step_en && res_valid),
      .res        (res),
      .out_ready  (out_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== bench/framed_stream_deframer_core_tb.sv =====
// Self-checking bench for framed_stream_deframer_core: builds framed byte streams,
// predicts every result from its own deframer model and checks the rsp stream.
// Depends on fsd_pkg and the deframer RTL.
module framed_stream_deframer_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import fsd_pkg::*;

   localparam logic OpByte = 1'b0;
   localparam logic OpEnd  = 1'b1;
   localparam logic [7:0] KindPadding    = 8'hFE;
   localparam logic [7:0] FirstReserved  = 8'h02;
   localparam logic [7:0] FirstSkippable = 8'h80;
   localparam logic [7:0] LastSkippable  = 8'hFD;
   localparam logic [47:0] IdentMagic    = 48'h59_70_50_61_4E_73;

   typedef enum logic [1:0] {PhStreamHdr, PhChunkHdr, PhChunkBody, PhError} parse_state_type;
   typedef enum int unsigned {IdentGood, IdentBadLength, IdentBadMagic} ident_flaw_type;

   typedef struct packed {
      bit       hold;
      item_type item;
   } stream_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [23:0] csr_wr_data = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic        req_tuser = 1'b0;
   logic [7:0]  req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [1:0]  rsp_tuser;
   logic [47:0] rsp_tdata;
   logic        rsp_tlast;

   stream_item_type stream_items[$];
   result_type      frame_results[$];
   int unsigned  req_pending = 0;
   int unsigned  items_queued = 0;
   int unsigned  results_seen = 0;
   int unsigned  streams_built = 0;
   int unsigned  mismatches = 0;
   int unsigned  req_gap = 0;
   int unsigned  rsp_stall = 0;
   bit           req_xfer = 1'b0;
   bit           hold_next = 1'b0;
   bit           req_gaps_on = 1'b1;
   bit           rsp_stalls_on = 1'b1;

   parse_state_type parse_state;
   logic [1:0]   hdr_pos;
   logic [7:0]   hdr_kind;
   logic [23:0]  chunk_len;
   logic [23:0]  body_cnt;
   logic [31:0]  stored_chk;
   logic [31:0]  payload_crc;
   logic         magic_ok;
   logic [23:0]  max_block;

   framed_stream_deframer_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tuser   (rsp_tuser),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

   always #5ns clock = ~clock;

   function automatic logic [31:0] crc32c_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] r;
      r = crc;
      for (int i = 0; i < 8; i++) begin
         r = (r >> 1) ^ ((r[0] ^ b[i]) ? CrcPolyRefl : 32'd0);
      end
      return r;
   endfunction

   function automatic logic [31:0] mask_crc(input logic [31:0] crc);
      logic [31:0] f;
      f = ~crc;
      return ((f >> 15) | (f << 17)) + CrcMaskAdd;
   endfunction

   function automatic int unsigned gap_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(6, 30);
   endfunction

   function automatic int unsigned short_len(input logic [23:0] lim);
      int unsigned n;
      n = ($urandom_range(0, 15) == 0) ? $urandom_range(9, 120) : $urandom_range(0, 8);
      return (n > lim) ? lim : n;
   endfunction

   task automatic clear_parser();
      parse_state = PhStreamHdr;
      hdr_pos = 2'd0;
      hdr_kind = '0;
      chunk_len = '0;
      body_cnt = '0;
      stored_chk = '0;
      payload_crc = CrcAllOnes;
      magic_ok = 1'b1;
   endtask

   task automatic open_body();
      body_cnt = '0;
      stored_chk = '0;
      payload_crc = CrcAllOnes;
      magic_ok = 1'b1;
      parse_state = PhChunkBody;
   endtask

   task automatic queue_result(input logic has, input logic [7:0] data, input logic comp,
                               input logic last, input logic [3:0] st,
                               input logic [31:0] chk);
      result_type r;
      r.has_byte = has;
      r.out_byte = data;
      r.compressed_payload = comp;
      r.chunk_end = last;
      r.status = st;
      r.expected_checksum = chk;
      frame_results.insert(frame_results.size(), r);
   endtask

   task automatic flag_error(input logic [3:0] st);
      queue_result(1'b0, 8'd0, 1'b0, 1'b1, st, 32'd0);
      parse_state = PhError;
   endtask

   task automatic deframe_item(input logic op, input logic [7:0] b);
      logic [23:0] pos;
      logic        data_kind;
      logic        comp;
      logic        has;
      logic        last;
      logic [3:0]  st;
      if (op == OpEnd) begin
         if (parse_state == PhChunkHdr && hdr_pos == 2'd0) begin
            queue_result(1'b0, 8'd0, 1'b0, 1'b1, StCleanEnd, 32'd0);
         end else if (parse_state != PhError) begin
            queue_result(1'b0, 8'd0, 1'b0, 1'b1, StEarlyEnd, 32'd0);
         end
         clear_parser();
      end else if (parse_state == PhStreamHdr || parse_state == PhChunkHdr) begin
         if (hdr_pos == 2'd0) begin
            hdr_kind = b;
            chunk_len = '0;
            hdr_pos = 2'd1;
         end else begin
            chunk_len[8 * (hdr_pos - 1) +: 8] = b;
            if (hdr_pos != 2'd3) begin
               hdr_pos++;
            end else begin
               hdr_pos = 2'd0;
               if (parse_state == PhStreamHdr) begin
                  if (hdr_kind != KindIdent) flag_error(StBadIdent);
                  else if (chunk_len != IdentSize) flag_error(StIdentLen);
                  else open_body();
               end else if (hdr_kind == KindIdent) begin
                  if (chunk_len != IdentSize) flag_error(StIdentLen);
                  else open_body();
               end else if (hdr_kind == KindCompressed || hdr_kind == KindUncompressed) begin
                  if (chunk_len < CheckSize) flag_error(StShort);
                  else if (hdr_kind == KindUncompressed && chunk_len - CheckSize > max_block)
                     flag_error(StLarge);
                  else open_body();
               end else if (hdr_kind <= LastUnskippable) begin
                  flag_error(StReserved);
               end else if (chunk_len == '0) begin
                  parse_state = PhChunkHdr;
               end else begin
                  open_body();
               end
            end
         end
      end else if (parse_state == PhChunkBody) begin
         pos = body_cnt;
         body_cnt++;
         last = (body_cnt == chunk_len);
         data_kind = (hdr_kind == KindCompressed || hdr_kind == KindUncompressed);
         if (hdr_kind == KindIdent) begin
            if (pos >= 6 || b != IdentMagic[8 * pos[2:0] +: 8]) magic_ok = 1'b0;
            if (last && !magic_ok) flag_error(StMagic);
            else if (last) parse_state = PhChunkHdr;
         end else if (data_kind) begin
            comp = (hdr_kind == KindCompressed);
            has = (pos >= 4);
            if (!has) stored_chk[8 * pos[1:0] +: 8] = b;
            else if (!comp) payload_crc = crc32c_byte(payload_crc, b);
            if (!last) begin
               if (has) queue_result(1'b1, b, comp, 1'b0, StOk, 32'd0);
            end else begin
               st = StOk;
               parse_state = PhChunkHdr;
               if (!comp && mask_crc(payload_crc) != stored_chk) begin
                  st = StChecksum;
                  parse_state = PhError;
               end
               queue_result(has, has ? b : 8'd0, comp, 1'b1, st, stored_chk);
            end
         end else if (last) begin
            parse_state = PhChunkHdr;
         end
      end
   endtask

   task automatic report_mismatch(input string msg);
      mismatches++;
      $display("MISMATCH at %0t: %s", $time, msg);
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("result %0d: %s is %0h, expected %0h",
                                   results_seen, name, got, want));
      end
   endtask

   task automatic check_result();
      result_type want;
      if (frame_results.size() == 0) begin
         report_mismatch($sformatf("result %0d arrived with none expected", results_seen));
      end else begin
         want = frame_results.pop_front();
         check_field("has_byte", rsp_tuser[0], want.has_byte);
         check_field("out_byte", rsp_tdata[7:0], want.out_byte);
         check_field("compressed_payload", rsp_tuser[1], want.compressed_payload);
         check_field("chunk_end", rsp_tlast, want.chunk_end);
         check_field("status", rsp_tdata[11:8], want.status);
         check_field("expected_checksum", rsp_tdata[43:12], want.expected_checksum);
      end
      results_seen++;
   endtask

   task automatic push_item(input logic op, input logic [7:0] b);
      stream_item_type s;
      s.hold = hold_next;
      s.item.op = op;
      s.item.data_byte = b;
      stream_items.insert(stream_items.size(), s);
      hold_next = 1'b0;
      req_pending++;
      items_queued++;
   endtask

   task automatic add_header(input logic [7:0] kind, input logic [23:0] len);
      push_item(OpByte, kind);
      push_item(OpByte, len[7:0]);
      push_item(OpByte, len[15:8]);
      push_item(OpByte, len[23:16]);
   endtask

   task automatic add_ident(input ident_flaw_type flaw);
      logic [47:0] body;
      logic [23:0] len;
      body = IdentMagic;
      len = IdentSize;
      if (flaw == IdentBadLength) begin
         len = 24'($urandom_range(0, 24'hFFFFFF));
         if (len == IdentSize) len = 24'd7;
      end
      if (flaw == IdentBadMagic) body = body ^ (48'd1 << $urandom_range(0, 47));
      add_header(KindIdent, len);
      if (flaw != IdentBadLength) begin
         for (int i = 0; i < 6; i++) push_item(OpByte, body[8 * i +: 8]);
      end
   endtask

   task automatic add_data_chunk(input bit comp, input int unsigned n, input bit bad_sum);
      logic [7:0]  body[$];
      logic [31:0] sum;
      sum = CrcAllOnes;
      for (int i = 0; i < n; i++) begin
         body.insert(body.size(), 8'($urandom));
         sum = crc32c_byte(sum, body[i]);
      end
      sum = comp ? $urandom() : mask_crc(sum);
      if (bad_sum) sum = sum ^ (32'd1 << $urandom_range(0, 31));
      add_header(comp ? KindCompressed : KindUncompressed, 24'(n + 4));
      for (int i = 0; i < 4; i++) push_item(OpByte, sum[8 * i +: 8]);
      foreach (body[i]) push_item(OpByte, body[i]);
   endtask

   task automatic add_filler(input logic [7:0] kind);
      int unsigned n;
      n = $urandom_range(0, 6);
      add_header(kind, 24'(n));
      repeat (n) push_item(OpByte, 8'($urandom));
   endtask

   task automatic add_stream(input logic [23:0] lim);
      int unsigned r;
      int unsigned chunks;
      bit          broken;
      streams_built++;
      broken = 1'b1;
      r = $urandom_range(0, 99);
      if (r < 4) add_header(8'($urandom_range(0, 254)), IdentSize);
      else if (r < 7) add_ident(IdentBadLength);
      else if (r < 10) add_ident(IdentBadMagic);
      else if (r < 12) repeat ($urandom_range(1, 9)) push_item(OpByte, 8'($urandom));
      else begin
         add_ident(IdentGood);
         broken = 1'b0;
      end
      chunks = $urandom_range(1, 5);
      while (!broken && chunks != 0) begin
         chunks--;
         r = $urandom_range(0, 99);
         if (r < 42) add_data_chunk(1'b0, short_len(lim), 1'b0);
         else if (r < 58) add_data_chunk(1'b1, short_len(24'hFFFFFF), 1'b0);
         else if (r < 63) begin
            add_data_chunk(1'b0, short_len(lim), 1'b1);
            broken = 1'b1;
         end else if (r < 68) add_filler(KindPadding);
         else if (r < 74) add_filler(8'($urandom_range(FirstSkippable, LastSkippable)));
         else if (r < 79) begin
            r = $urandom_range(0, 5);
            if (r == 0) add_ident(IdentBadLength);
            else if (r == 1) add_ident(IdentBadMagic);
            else add_ident(IdentGood);
            broken = (r < 2);
         end else if (r < 83) begin
            add_header(8'($urandom_range(FirstReserved, LastUnskippable)), 24'($urandom));
            broken = 1'b1;
         end else if (r < 87) begin
            add_header($urandom_range(0, 1) ? KindCompressed : KindUncompressed,
                       24'($urandom_range(0, 3)));
            broken = 1'b1;
         end else if (r < 91 && lim <= 24'hFFFFFA) begin
            add_header(KindUncompressed,
                       $urandom_range(0, 3) == 0 ? 24'hFFFFFF : lim + 24'd5);
            broken = 1'b1;
         end else add_data_chunk(1'b0, short_len(lim), 1'b0);
      end
      if (broken) begin
         repeat ($urandom_range(0, 3)) push_item(OpByte, 8'($urandom));
      end else if ($urandom_range(0, 9) == 0) begin
         r = $urandom_range(0, 2);
         if (r == 0) repeat ($urandom_range(1, 3)) push_item(OpByte, 8'($urandom));
         else begin
            add_header(r == 1 ? KindCompressed : KindPadding,
                       24'($urandom_range(16, 24'hFFFFFF)));
            repeat ($urandom_range(0, 12)) push_item(OpByte, 8'($urandom));
         end
      end
      if ($urandom_range(0, 19) == 0) begin
         repeat ($urandom_range(1, 4))
            push_item($urandom_range(0, 3) == 0 ? OpEnd : OpByte, 8'($urandom));
      end
      push_item(OpEnd, 8'($urandom));
   endtask

   task automatic wait_idle();
      while (req_pending != 0 || frame_results.size() != 0) @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   // Inputs move on the falling edge; a transfer seen at the rising edge frees the slot.
   always @(negedge clock) begin : drive_req
      stream_item_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_xfer) begin
         if (req_gap != 0) begin
            req_gap--;
            req_tvalid <= 1'b0;
         end else if (stream_items.size() != 0 &&
                      !(stream_items[0].hold && frame_results.size() != 0)) begin
            nxt = stream_items.pop_front();
            req_tvalid <= 1'b1;
            req_tuser <= nxt.item.op;
            req_tdata <= nxt.item.data_byte;
            req_gap = req_gaps_on ? gap_len() : 0;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (rsp_stall != 0) begin
         rsp_tready <= 1'b0;
         rsp_stall--;
      end else begin
         rsp_tready <= 1'b1;
         if (rsp_stalls_on) rsp_stall = gap_len();
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         clear_parser();
         max_block = MaxBlockSizeReset;
         req_xfer = 1'b0;
      end else begin
         if (csr_wr_en) max_block = csr_wr_data;
         req_xfer = req_tvalid && req_tready;
         if (req_xfer) begin
            deframe_item(req_tuser, req_tdata);
            req_pending--;
         end
         if (rsp_tvalid && rsp_tready) check_result();
      end
   end

   initial begin
      logic [23:0] block_sizes [6];
      int unsigned first;
      block_sizes = '{MaxBlockSizeReset, 24'd0, 24'hFFFFFF, 24'd1, 24'd0, 24'd12};
      block_sizes[4] = 24'($urandom_range(2, 24'hFFFFFE));

      push_item(OpEnd, 8'hFF);
      add_header(KindCompressed, IdentSize);
      push_item(OpByte, 8'hFF);
      push_item(OpEnd, 8'h00);
      add_header(KindIdent, 24'hFFFFFF);
      push_item(OpEnd, 8'h00);
      add_ident(IdentGood);
      add_data_chunk(1'b1, 0, 1'b0);
      push_item(OpEnd, 8'h00);

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      wait_idle();

      for (int p = 0; p < 6; p++) begin
         if (p != 0) begin
            csr_wr_en <= 1'b1;
            csr_wr_data <= block_sizes[p];
            @(negedge clock);
            csr_wr_en <= 1'b0;
         end
         req_gaps_on = (p != 1) && (p != 4);
         rsp_stalls_on = (p != 1) && (p != 3);
         first = items_queued;
         for (int k = 0; items_queued - first < 240; k++) begin
            // The second stream of each setting waits for all earlier results to drain.
            hold_next = (k == 1) || ($urandom_range(0, 9) == 0);
            add_stream(block_sizes[p]);
         end
         wait_idle();
      end

      $display("Run covered %0d input transfers in %0d streams over 6 block size limits.",
               items_queued, streams_built);
      $display("Checked %0d result transfers, %0d mismatches.", results_seen, mismatches);
      if (mismatches == 0 && frame_results.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("Timeout with %0d transfers pending.", req_pending);
      $display("CHECK FAILED");
      $finish;
   end

endmodule
